### hw/rtl/assert_macros.svh
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/sfpe_pkg.sv
package sfpe_pkg;

    localparam int MAX_IONS  = 64;
    localparam int MAX_GRID  = 256;
    localparam int FRAC_BITS = 30;
    localparam int ION_W     = $clog2(MAX_IONS);
    localparam int IDX_W     = $clog2(MAX_GRID);
    localparam int SIZE_W    = 9;
    localparam int ADDR_W    = ION_W + IDX_W;
    localparam int MEM_DEPTH = MAX_IONS * MAX_GRID;

    typedef enum logic [1:0] {
        K_LOAD_X = 2'd0,
        K_LOAD_Y = 2'd1,
        K_LOAD_Z = 2'd2,
        K_QUERY  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } t_reg;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_cplx;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [65:0] HALF    = 66'sd1 <<< (FRAC_BITS - 1);
    localparam t_cplx C_ONE  = '{re: 32'sd1 <<< FRAC_BITS, im: 32'sd0};
    localparam t_cplx C_ZERO = '{re: 32'sd0, im: 32'sd0};

    // round((p1 +/- p2) / 2^F), ties up, saturated
    function automatic logic signed [31:0] fx_sum(input logic signed [63:0] p1,
                                                  input logic signed [63:0] p2,
                                                  input logic sub);
        logic signed [65:0] s;
        logic signed [65:0] q;
        s = 66'(p1) + (sub ? -66'(p2) : 66'(p2)) + HALF;
        q = s >>> FRAC_BITS;
        if (q > 66'(S32_MAX)) begin
            return S32_MAX;
        end else if (q < 66'(S32_MIN)) begin
            return S32_MIN;
        end
        return q[31:0];
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        return (v == S32_MIN) ? S32_MAX : -v;
    endfunction

    // clamp to [2, MAX_GRID], round down to even
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] c;
        c = v;
        if (c < SIZE_W'(2)) c = SIZE_W'(2);
        if (c > SIZE_W'(MAX_GRID)) c = SIZE_W'(MAX_GRID);
        return {c[SIZE_W-1:1], 1'b0};
    endfunction

endpackage

### hw/rtl/structure_factor_phase_engine.sv
// Structure factor phase engine. A load word (kind 0..2) fills one axis
// table of one ion from its unit phase for an axis of n points, busy
// throughout. A query word (kind 3) answers phase*X[i]*Y[j]*Z[k] after
// a table read and three complex multiplies, or with zero in the following
// cycle when an index is out of range. Loads and queries use the single
// shared 32x32 multiplier: a complex multiply takes four products and a
// rounding step. o_done marks the result for one cycle and cannot be held off.
// Tables hold nothing defined until loaded; there is no clearing pass.
module structure_factor_phase_engine import sfpe_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [1:0]          i_kind,
    input  logic [5:0]          i_ion_index,
    input  logic signed [31:0]  i_phase_re,
    input  logic signed [31:0]  i_phase_im,
    input  logic [7:0]          i_grid_i,
    input  logic [7:0]          i_grid_j,
    input  logic [7:0]          i_grid_k,
    output logic                o_done,
    output logic signed [31:0]  o_factor_re,
    output logic signed [31:0]  o_factor_im,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_LZER = 10'b00_0000_0010,
        S_LMUL = 10'b00_0000_0100,
        S_LWR1 = 10'b00_0000_1000,
        S_LWR2 = 10'b00_0001_0000,
        S_LMID = 10'b00_0010_0000,
        S_QRD  = 10'b00_0100_0000,
        S_QM1  = 10'b00_1000_0000,
        S_QM2  = 10'b01_0000_0000,
        S_QM3  = 10'b10_0000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_size_x, r_size_y, r_size_z;
    t_kind               r_kind;
    logic [ION_W-1:0]    r_ion;
    t_cplx               r_ph;
    logic [IDX_W-1:0]    r_gi, r_gj, r_gk;
    logic [SIZE_W-1:0]   r_n;
    logic [IDX_W-1:0]    r_k;
    logic [2:0]          r_mc;
    logic signed [63:0]  r_prod, r_acc;
    logic signed [31:0]  r_tre;
    t_cplx               r_res;
    t_cplx               r_rd_x, r_rd_y, r_rd_z;
    logic                r_done;
    logic signed [31:0]  r_out_re, r_out_im;

    logic [63:0] mem_x [MEM_DEPTH];
    logic [63:0] mem_y [MEM_DEPTH];
    logic [63:0] mem_z [MEM_DEPTH];

    logic [SIZE_W-1:0]   nx, ny, nz, h;
    logic                accept, in_range;
    t_cplx               op_a, op_b, wr_data;
    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  mul_p;
    logic                mul_last;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;

    assign nx = eff_size(r_size_x);
    assign ny = eff_size(r_size_y);
    assign nz = eff_size(r_size_z);
    assign h  = r_n >> 1;

    assign accept   = i_start && (r_state == S_IDLE);
    assign in_range = ({3'b000, i_ion_index} < 9'(MAX_IONS))
                      && ({1'b0, i_grid_i} < nx) && ({1'b0, i_grid_j} < ny)
                      && ({1'b0, i_grid_k} < nz);

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_factor_re = r_out_re;
    assign o_factor_im = r_out_im;

    // operand routing for the shared complex multiply
    always_comb begin
        case (r_state)
            S_QM1: begin
                op_a = r_rd_y;
                op_b = r_rd_z;
            end
            S_QM2: begin
                op_a = r_rd_x;
                op_b = r_res;
            end
            S_QM3: begin
                op_a = r_ph;
                op_b = r_res;
            end
            default: begin
                op_a = r_res;
                op_b = r_ph;
            end
        endcase
        case (r_mc)
            3'd0: begin
                mul_a = op_a.re;
                mul_b = op_b.re;
            end
            3'd1: begin
                mul_a = op_a.im;
                mul_b = op_b.im;
            end
            3'd2: begin
                mul_a = op_a.re;
                mul_b = op_b.im;
            end
            default: begin
                mul_a = op_a.im;
                mul_b = op_b.re;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign mul_last = (r_mc == 3'd4);

    // table write port
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_data = r_res;
        case (r_state)
            S_LZER: begin
                wr_en   = 1'b1;
                wr_data = C_ONE;
            end
            S_LWR1: begin
                wr_en  = 1'b1;
                wr_idx = r_k;
            end
            S_LWR2: begin
                wr_en   = 1'b1;
                wr_idx  = IDX_W'(r_n - SIZE_W'(r_k));
                wr_data = '{re: r_res.re, im: neg_sat(r_res.im)};
            end
            S_LMID: begin
                wr_en   = 1'b1;
                wr_idx  = h[IDX_W-1:0];
                wr_data = C_ZERO;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_kind == K_LOAD_X) mem_x[{r_ion, wr_idx}] <= wr_data;
        if (wr_en && r_kind == K_LOAD_Y) mem_y[{r_ion, wr_idx}] <= wr_data;
        if (wr_en && r_kind == K_LOAD_Z) mem_z[{r_ion, wr_idx}] <= wr_data;
        if (r_state == S_QRD) begin
            r_rd_x <= mem_x[{r_ion, r_gi}];
            r_rd_y <= mem_y[{r_ion, r_gj}];
            r_rd_z <= mem_z[{r_ion, r_gk}];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && t_kind'(i_kind) != K_QUERY) begin
                    n_state = S_LZER;
                end else if (accept && in_range) begin
                    n_state = S_QRD;
                end
            end
            S_LZER: n_state = (h == SIZE_W'(1)) ? S_LMID : S_LMUL;
            S_LMUL: if (mul_last) n_state = S_LWR1;
            S_LWR1: n_state = S_LWR2;
            S_LWR2: n_state = (SIZE_W'(r_k) + SIZE_W'(1) == h) ? S_LMID : S_LMUL;
            S_LMID: n_state = S_IDLE;
            S_QRD:  n_state = S_QM1;
            S_QM1:  if (mul_last) n_state = S_QM2;
            S_QM2:  if (mul_last) n_state = S_QM3;
            S_QM3:  if (mul_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_mc     <= '0;
            r_size_x <= SIZE_W'(64);
            r_size_y <= SIZE_W'(64);
            r_size_z <= SIZE_W'(64);
        end else begin
            r_state <= n_state;
            // strobe for an out-of-range query or the last rounding of a query
            r_done  <= (accept && t_kind'(i_kind) == K_QUERY && !in_range)
                       || (r_state == S_QM3 && mul_last);
            if (i_cfg_valid) begin
                case (t_reg'(i_cfg_index))
                    REG_SIZE_X: r_size_x <= i_cfg_data;
                    REG_SIZE_Y: r_size_y <= i_cfg_data;
                    REG_SIZE_Z: r_size_z <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_LMUL || r_state == S_QM1 || r_state == S_QM2
                    || r_state == S_QM3) begin
                r_mc <= mul_last ? 3'd0 : r_mc + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= t_kind'(i_kind);
            r_ion  <= i_ion_index;
            r_ph   <= '{re: i_phase_re, im: i_phase_im};
            r_gi   <= i_grid_i;
            r_gj   <= i_grid_j;
            r_gk   <= i_grid_k;
            case (t_kind'(i_kind))
                K_LOAD_X: r_n <= nx;
                K_LOAD_Y: r_n <= ny;
                default:  r_n <= nz;
            endcase
            r_out_re <= '0;
            r_out_im <= '0;
        end
        if (r_state == S_LZER) begin
            r_res <= C_ONE;
            r_k   <= IDX_W'(1);
        end
        if (r_state == S_LWR2) r_k <= r_k + IDX_W'(1);
        // one product per cycle; round the real part after the second,
        // the imaginary part after the fourth
        r_prod <= mul_p;
        case (r_mc)
            3'd1, 3'd3: r_acc <= r_prod;
            3'd2:       r_tre <= fx_sum(r_acc, r_prod, 1'b1);
            3'd4:       r_res <= '{re: r_tre, im: fx_sum(r_acc, r_prod, 1'b0)};
            default: ;
        endcase
        if (r_state == S_QM3 && mul_last) begin
            r_out_re <= r_tre;
            r_out_im <= fx_sum(r_acc, r_prod, 1'b0);
        end
    end

endmodule

### hw/rtl/sfpe_checker.sv
`include "assert_macros.svh"

module sfpe_checker import sfpe_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic [1:0] i_kind,
    input logic       o_done
);

    // every accepted word either keeps the block busy or answers at once
    `ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, i_start && !o_busy, o_busy || o_done)
    // a load never produces a result word
    `ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, i_start && !o_busy && t_kind'(i_kind) != K_QUERY, !o_done)
    // a result only follows work in flight or a word just taken
    `ASSERT_SAME(a_done_cause, i_clk, i_rst_n, o_done, $past(o_busy) || $past(i_start))

endmodule

bind structure_factor_phase_engine sfpe_checker u_sfpe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .i_kind  (i_kind),
    .o_done  (o_done)
);
